// ----- sv/krt_pkg.sv -----
// krt_pkg: shared types, codes and helpers for the keyed record table
// used by krt_ctrl, krt_dp, keyed_record_table and krt_checker; no dependencies
`timescale 1ns / 1ps

package krt_pkg;

  localparam int unsigned POOL_SLOTS_DEF = 64;
  localparam int unsigned OP_W = 2;
  localparam int unsigned KEY_W = 24;
  localparam int unsigned NUM_W = 32;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ADDED     = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_FOUND     = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_DELETED   = 3'd4
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] name_key;
    logic [NUM_W-1:0] number_value;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    number_out;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;      // latch a new word, restart walk and scan
    logic    clear_step;  // clear one in-use bit after reset
    logic    scan_step;   // move free-slot scan to the next slot
    logic    walk_step;   // follow the link to the next record
    logic    add_commit;  // write the new record into the scanned slot
    logic    del_commit;  // unlink and free the current record
    logic    set_res;     // capture result status and number
    status_e res_status;
    logic    load_out;    // move captured result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cur_null;    // walk pointer is the null marker
    logic walk_limit;  // walk has visited every slot
    logic key_hit;     // current record key matches
    logic slot_busy;   // scanned slot is in use
    logic scan_last;   // scan counter sits on the last slot
  } flags_t;

  // three-byte strncmp equality, first byte in the top bits
  function automatic logic keys_match(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    logic res;
    res = 1'b0;
    if (a[23:16] != b[23:16]) begin
      res = 1'b0;
    end else if (a[23:16] == 8'd0) begin
      res = 1'b1;
    end else if (a[15:8] != b[15:8]) begin
      res = 1'b0;
    end else if (a[15:8] == 8'd0) begin
      res = 1'b1;
    end else begin
      res = (a[7:0] == b[7:0]);
    end
    return res;
  endfunction

endpackage

// ----- sv/keyed_record_table.sv -----
// keyed_record_table: top level joining the controller and the datapath
// depends on krt_pkg, krt_ctrl and krt_dp
`timescale 1ns / 1ps

// A pool of POOL_SLOTS records (24-bit name key, 32-bit number) kept as a
// singly linked list, newest record at the head. Each accepted word gives
// exactly one result word. Add takes the lowest free slot (status added, or
// table full). Search returns the number of the newest record whose key
// matches (found / not found); delete unlinks and frees it (deleted / not
// found). Keys compare like a three-byte strncmp: bytes after a shared zero
// byte are ignored. An unused operation code answers not found and changes
// nothing. number_out is zero unless the status is found. One word is in
// work at a time; in_stall_o is low only while the block waits for a word.
// Add scans the in-use bits from slot zero up; search and delete walk the
// list from the head, visiting at most POOL_SLOTS records. The slot
// memories give one record (or one in-use bit during the free-slot scan)
// per cycle. After reset a clearing pass resets the in-use bits, with
// in_stall_o held high. A result waits in an output register, so a
// stalled result does not block the next word from being accepted.

module keyed_record_table #(
  parameter int unsigned POOL_SLOTS = krt_pkg::POOL_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  krt_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output krt_pkg::out_word_t out_word_o
);

  krt_pkg::cmd_t   cmd;
  krt_pkg::flags_t flags;

  // sequencing: clear pass, idle, free-slot scan, list walk, result hand-off
  krt_ctrl u_krt_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_word_i.operation),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  // memories, head and walk pointers, result and output registers
  krt_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_krt_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .flags_o    (flags),
    .out_word_o (out_word_o)
  );

endmodule

// ----- sv/krt_ctrl.sv -----
// krt_ctrl: sequencing state machine of the keyed record table
// depends on krt_pkg; drives krt_dp through cmd_t and reads its flags_t
`timescale 1ns / 1ps

module krt_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [krt_pkg::OP_W-1:0]    in_op_i,
  output logic                        in_stall_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  krt_pkg::flags_t             flags_i,
  output krt_pkg::cmd_t               cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [krt_pkg::OP_W-1:0] op_q;
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.res_status = krt_pkg::STATUS_NOT_FOUND;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (flags_i.scan_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (in_op_i)
            krt_pkg::OP_ADD: begin
              state_d = S_SCAN;
            end
            krt_pkg::OP_SEARCH, krt_pkg::OP_DELETE: begin
              state_d = S_WALK;
            end
            default: begin
              cmd_o.set_res = 1'b1;
              cmd_o.res_status = krt_pkg::STATUS_NOT_FOUND;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!flags_i.slot_busy) begin
          cmd_o.add_commit = 1'b1;
          cmd_o.set_res = 1'b1;
          cmd_o.res_status = krt_pkg::STATUS_ADDED;
          state_d = S_DONE;
        end else if (flags_i.scan_last) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_status = krt_pkg::STATUS_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_WALK: begin
        if (flags_i.cur_null || flags_i.walk_limit) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_status = krt_pkg::STATUS_NOT_FOUND;
          state_d = S_DONE;
        end else if (flags_i.key_hit) begin
          cmd_o.set_res = 1'b1;
          if (op_q == krt_pkg::OP_DELETE) begin
            cmd_o.del_commit = 1'b1;
            cmd_o.res_status = krt_pkg::STATUS_DELETED;
          end else begin
            cmd_o.res_status = krt_pkg::STATUS_FOUND;
          end
          state_d = S_DONE;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      op_q <= krt_pkg::OP_ADD;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.accept) begin
        op_q <= in_op_i;
      end
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/krt_dp.sv -----
// krt_dp: record memories, list pointers, scan counter and result registers
// depends on krt_pkg; commanded by krt_ctrl
`timescale 1ns / 1ps

module krt_dp #(
  parameter int unsigned POOL_SLOTS = krt_pkg::POOL_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  krt_pkg::in_word_t   in_word_i,
  input  krt_pkg::cmd_t       cmd_i,
  output krt_pkg::flags_t     flags_o,
  output krt_pkg::out_word_t  out_word_o
);

  localparam int unsigned IDX_W = $clog2(POOL_SLOTS);
  localparam int unsigned LINK_W = $clog2(POOL_SLOTS + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);

  // slot memories
  logic [krt_pkg::KEY_W-1:0] key_mem [POOL_SLOTS];
  logic [krt_pkg::NUM_W-1:0] num_mem [POOL_SLOTS];
  logic [LINK_W-1:0]         link_mem [POOL_SLOTS];
  logic                      use_mem [POOL_SLOTS];

  logic [krt_pkg::KEY_W-1:0] key_rd_q;
  logic [krt_pkg::NUM_W-1:0] num_rd_q;
  logic [LINK_W-1:0]         link_rd_q;
  logic                      use_rd_q;

  logic [LINK_W-1:0] head_q, cur_q, prev_q, steps_q;
  logic [IDX_W-1:0]  scan_q;
  logic [krt_pkg::KEY_W-1:0] key_q;
  logic [krt_pkg::NUM_W-1:0] num_q;
  krt_pkg::status_e          res_status_q;
  logic [krt_pkg::NUM_W-1:0] res_num_q;
  krt_pkg::out_word_t        out_word_q;

  logic [LINK_W-1:0] walk_link;
  logic [IDX_W-1:0]  walk_idx, use_rd_idx, use_wa, link_wa, scan_inc;
  logic              use_we, use_wd, link_we, prev_null, scan_last;
  logic [LINK_W-1:0] link_wd;

  assign scan_last = (scan_q == LAST_IDX);
  assign scan_inc = scan_last ? '0 : scan_q + IDX_W'(1);
  assign prev_null = (prev_q >= NULL_LINK);

  // walk reads the head on accept, then follows the link just read
  assign walk_link = cmd_i.accept ? head_q : link_rd_q;
  assign walk_idx = (walk_link >= NULL_LINK) ? '0 : walk_link[IDX_W-1:0];
  assign use_rd_idx = cmd_i.accept ? '0 : scan_inc;

  assign use_we = cmd_i.clear_step || cmd_i.add_commit || cmd_i.del_commit;
  assign use_wa = cmd_i.del_commit ? cur_q[IDX_W-1:0] : scan_q;
  assign use_wd = cmd_i.add_commit;

  assign link_we = cmd_i.add_commit || (cmd_i.del_commit && !prev_null);
  assign link_wa = cmd_i.add_commit ? scan_q : prev_q[IDX_W-1:0];
  assign link_wd = cmd_i.add_commit ? head_q : link_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_commit) begin
      key_mem[scan_q] <= key_q;
      num_mem[scan_q] <= num_q;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (use_we) begin
      use_mem[use_wa] <= use_wd;
    end
    key_rd_q <= key_mem[walk_idx];
    num_rd_q <= num_mem[walk_idx];
    link_rd_q <= link_mem[walk_idx];
    use_rd_q <= use_mem[use_rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= NULL_LINK;
      scan_q <= '0;
    end else begin
      if (cmd_i.add_commit) begin
        head_q <= LINK_W'(scan_q);
      end else if (cmd_i.del_commit && prev_null) begin
        head_q <= link_rd_q;
      end
      if (cmd_i.accept) begin
        scan_q <= '0;
      end else if (cmd_i.clear_step || cmd_i.scan_step) begin
        scan_q <= scan_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q <= in_word_i.name_key;
      num_q <= in_word_i.number_value;
      cur_q <= head_q;
      prev_q <= NULL_LINK;
      steps_q <= '0;
    end else if (cmd_i.walk_step) begin
      prev_q <= cur_q;
      cur_q <= link_rd_q;
      steps_q <= steps_q + LINK_W'(1);
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_num_q <= (cmd_i.res_status == krt_pkg::STATUS_FOUND) ? num_rd_q : '0;
    end
    if (cmd_i.load_out) begin
      out_word_q.status <= res_status_q;
      out_word_q.number_out <= res_num_q;
    end
  end

  assign flags_o.cur_null = (cur_q >= NULL_LINK);
  assign flags_o.walk_limit = (steps_q == NULL_LINK);
  assign flags_o.key_hit = krt_pkg::keys_match(key_q, key_rd_q);
  assign flags_o.slot_busy = use_rd_q;
  assign flags_o.scan_last = scan_last;

  assign out_word_o = out_word_q;

endmodule

// ----- sv/krt_checker.sv -----
// krt_checker: port-level assertions for keyed_record_table
// depends on krt_pkg; attached to the top level by the bind below
`timescale 1ns / 1ps

module krt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input krt_pkg::out_word_t out_word_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  // number is only carried by a found result
  a_num_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.status == krt_pkg::STATUS_FOUND) ||
                    (out_word_o.number_out == '0))
    else $error("nonzero number on a result that is not found");

  // one word in work at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted while one is in work");

endmodule

bind keyed_record_table krt_checker u_krt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
